/* sv/vcc_pkg.sv */
`timescale 1ns / 1ps

package vcc_pkg;

    // Field and register widths
    localparam int FUNC_W   = 2;
    localparam int SEL_W    = 2;
    localparam int CENT_W   = 16;
    localparam int VALUE_W  = 8;
    localparam int STOCK_W  = 8;
    localparam int STATUS_W = 2;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = CENT_W;

    // Divider step counter: one quotient bit per step
    localparam int DIV_STEPS = CENT_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    // Parameter defaults and register-backed limits
    localparam int NUM_DRINKS_DEF = 4;
    localparam int NUM_COINS_DEF  = 3;
    localparam int PRICE_REGS     = 4;
    localparam int VALUE_REGS     = 3;

    localparam logic [CENT_W-1:0]  DOLLAR_CENTS  = 16'd100;
    localparam logic [CENT_W-1:0]  CENT_MAX      = 16'hFFFF;
    localparam logic [STOCK_W-1:0] STOCK_MAX     = 8'hFF;
    localparam logic [STOCK_W-1:0] DRINK_STOCK_INIT = 8'd5;

    localparam logic [CENT_W-1:0]  PRICE_INIT_0 = 16'd75;
    localparam logic [CENT_W-1:0]  PRICE_INIT_1 = 16'd75;
    localparam logic [CENT_W-1:0]  PRICE_INIT_2 = 16'd80;
    localparam logic [CENT_W-1:0]  PRICE_INIT_3 = 16'd80;
    localparam logic [VALUE_W-1:0] VALUE_INIT_0 = 8'd25;
    localparam logic [VALUE_W-1:0] VALUE_INIT_1 = 8'd10;
    localparam logic [VALUE_W-1:0] VALUE_INIT_2 = 8'd5;

    // Function codes
    localparam logic [FUNC_W-1:0] FUNC_COIN   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_DOLLAR = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_SELECT = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_RETURN = 2'd3;

    // Result status codes
    localparam logic [STATUS_W-1:0] STAT_CREDIT = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_VEND   = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_REFUSE = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_CHANGE = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PRICE_0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PRICE_1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PRICE_2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PRICE_3 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_VALUE_0 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_VALUE_1 = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_VALUE_2 = 3'd6;

    typedef struct packed {
        logic               done;
        logic [CENT_W-1:0]  quotient;
        logic [VALUE_W-1:0] remainder;
    } div_result_t;

    function automatic logic [STOCK_W-1:0] coin_stock_init(input int idx);
        logic [STOCK_W-1:0] v;
        case (idx)
            0:       v = 8'd5;
            1:       v = 8'd5;
            2:       v = 8'd10;
            default: v = 8'd0;
        endcase
        return v;
    endfunction

endpackage

/* sv/vending_change_controller_unit.sv */
`timescale 1ns / 1ps

// Vending controller with greedy change. Raise start while busy is low to hand
// in a transaction (func, drink_sel, coin_sel); it is taken at the rising edge
// where both hold. Coin insert, dollar insert and drink select each pass
// through ST_EXEC, which keeps busy high, and then put one result on the
// output ports from the result registers. Coin return first loads the balance
// (ST_RET_LOAD), then gives one change entry per coin type, in coin index
// order. Each entry divides the remaining balance by the coin value in the
// shared 16-step bit-serial divider: ST_DIV_GO starts the divider, ST_DIV_WAIT
// waits for its 16 steps and the done flag, and ST_FIX forms the entry; busy
// stays high throughout. Results appear on the output ports for exactly one
// cycle, marked by strobe; the receiver cannot stall them, so it must capture
// every strobed cycle. The last output is high on the final result of a
// transaction. Busy is already low in the cycle that carries that result, so
// the next transaction can be taken at the edge that ends it. Prices and coin
// values are written through cfg_we / cfg_index / cfg_data; the user must do
// so only while busy is low, as the block does not enforce it; index 7 is
// ignored.
module vending_change_controller_unit
#(
    parameter int NUM_DRINKS = vcc_pkg::NUM_DRINKS_DEF,
    parameter int NUM_COINS  = vcc_pkg::NUM_COINS_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [vcc_pkg::FUNC_W-1:0]        func,
    input  logic [vcc_pkg::SEL_W-1:0]         drink_sel,
    input  logic [vcc_pkg::SEL_W-1:0]         coin_sel,
    input  logic                              cfg_we,
    input  logic [vcc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [vcc_pkg::CFG_DATA_W-1:0]    cfg_data,
    output logic                              strobe,
    output logic [vcc_pkg::STATUS_W-1:0]      status,
    output logic [vcc_pkg::CENT_W-1:0]        credit,
    output logic [vcc_pkg::SEL_W-1:0]         drink_index,
    output logic [vcc_pkg::SEL_W-1:0]         coin_index,
    output logic [vcc_pkg::STOCK_W-1:0]       coin_count,
    output logic [vcc_pkg::CENT_W-1:0]        leftover,
    output logic                              last
);

    // Only slots and coin types that have a price or value register exist
    localparam int DRINK_SLOTS = (NUM_DRINKS < vcc_pkg::PRICE_REGS) ?
                                 NUM_DRINKS : vcc_pkg::PRICE_REGS;
    localparam int COIN_TYPES  = (NUM_COINS < vcc_pkg::VALUE_REGS) ?
                                 NUM_COINS : vcc_pkg::VALUE_REGS;

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_EXEC,
        ST_RET_LOAD,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_FIX
    } state_t;

    state_t                            state_reg, state_next;

    logic [vcc_pkg::CENT_W-1:0]        price_reg [vcc_pkg::PRICE_REGS];
    logic [vcc_pkg::VALUE_W-1:0]       value_reg [vcc_pkg::VALUE_REGS];
    logic [vcc_pkg::CENT_W-1:0]        balance_reg, balance_next;
    logic [vcc_pkg::STOCK_W-1:0]       drink_stock_reg [DRINK_SLOTS];
    logic [vcc_pkg::STOCK_W-1:0]       drink_stock_next [DRINK_SLOTS];
    logic [vcc_pkg::STOCK_W-1:0]       coin_stock_reg [COIN_TYPES];
    logic [vcc_pkg::STOCK_W-1:0]       coin_stock_next [COIN_TYPES];

    // Latched transaction
    logic [vcc_pkg::FUNC_W-1:0]        func_reg, func_next;
    logic [vcc_pkg::SEL_W-1:0]         dsel_reg, dsel_next;
    logic [vcc_pkg::SEL_W-1:0]         csel_reg, csel_next;

    // Change sequencer
    logic [vcc_pkg::SEL_W-1:0]         coin_k_reg, coin_k_next;
    logic [vcc_pkg::CENT_W-1:0]        rest_reg, rest_next;
    logic [vcc_pkg::CENT_W-1:0]        prod_reg, prod_next;

    // Registered result
    logic                              strobe_reg, strobe_next;
    logic [vcc_pkg::STATUS_W-1:0]      status_reg, status_next;
    logic [vcc_pkg::CENT_W-1:0]        credit_reg, credit_next;
    logic [vcc_pkg::SEL_W-1:0]         drink_idx_reg, drink_idx_next;
    logic [vcc_pkg::SEL_W-1:0]         coin_idx_reg, coin_idx_next;
    logic [vcc_pkg::STOCK_W-1:0]       count_reg, count_next;
    logic [vcc_pkg::CENT_W-1:0]        left_reg, left_next;
    logic                              last_reg, last_next;

    // Selected operands
    logic [vcc_pkg::STOCK_W-1:0]       dstock_sel;
    logic [vcc_pkg::STOCK_W-1:0]       cstock_in_sel;
    logic [vcc_pkg::STOCK_W-1:0]       cstock_k_sel;
    logic [vcc_pkg::VALUE_W-1:0]       value_k;
    logic [vcc_pkg::CENT_W:0]          credit_sum;
    logic [vcc_pkg::CENT_W-1:0]        credit_add;
    logic                              drink_known;
    logic                              coin_known;
    logic                              vend_ok;
    logic                              over_stock;
    logic                              last_coin;
    logic                              div_go;
    vcc_pkg::div_result_t              div_res;

    vcc_divider u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .go       (div_go),
        .dividend (rest_reg),
        .divisor  (value_k),
        .res      (div_res)
    );

    assign div_go = (state_reg == ST_DIV_GO);

    // Stock selection by latched indexes
    always_comb
    begin
        dstock_sel    = '0;
        cstock_in_sel = '0;
        cstock_k_sel  = '0;
        for (int i = 0; i < DRINK_SLOTS; i++)
        begin
            if (vcc_pkg::SEL_W'(i) == dsel_reg)
            begin
                dstock_sel = drink_stock_reg[i];
            end
        end
        for (int i = 0; i < COIN_TYPES; i++)
        begin
            if (vcc_pkg::SEL_W'(i) == csel_reg)
            begin
                cstock_in_sel = coin_stock_reg[i];
            end
            if (vcc_pkg::SEL_W'(i) == coin_k_reg)
            begin
                cstock_k_sel = coin_stock_reg[i];
            end
        end
    end

    assign drink_known = ({1'b0, dsel_reg} < (vcc_pkg::SEL_W+1)'(DRINK_SLOTS));
    assign coin_known  = ({1'b0, csel_reg} < (vcc_pkg::SEL_W+1)'(COIN_TYPES));
    assign value_k     = (coin_k_reg < vcc_pkg::SEL_W'(vcc_pkg::VALUE_REGS)) ?
                         value_reg[coin_k_reg] : '0;
    assign vend_ok     = drink_known && (dstock_sel != '0) &&
                         (balance_reg >= price_reg[dsel_reg]);
    assign last_coin   = (coin_k_reg == vcc_pkg::SEL_W'(COIN_TYPES - 1));
    assign over_stock  = (div_res.quotient > {8'd0, cstock_k_sel});

    // Credit to add: dollar, or the inserted coin's value (unknown coin adds 0)
    always_comb
    begin
        credit_add = '0;
        if (func_reg == vcc_pkg::FUNC_DOLLAR)
        begin
            credit_add = vcc_pkg::DOLLAR_CENTS;
        end
        else if (coin_known && (csel_reg < vcc_pkg::SEL_W'(vcc_pkg::VALUE_REGS)))
        begin
            credit_add = {8'd0, value_reg[csel_reg]};
        end
    end

    assign credit_sum = {1'b0, balance_reg} + {1'b0, credit_add};

    always_comb
    begin
        state_next     = state_reg;
        balance_next   = balance_reg;
        func_next      = func_reg;
        dsel_next      = dsel_reg;
        csel_next      = csel_reg;
        coin_k_next    = coin_k_reg;
        rest_next      = rest_reg;
        prod_next      = prod_reg;
        strobe_next    = 1'b0;
        status_next    = status_reg;
        credit_next    = credit_reg;
        drink_idx_next = drink_idx_reg;
        coin_idx_next  = coin_idx_reg;
        count_next     = count_reg;
        left_next      = left_reg;
        last_next      = last_reg;
        for (int i = 0; i < DRINK_SLOTS; i++)
        begin
            drink_stock_next[i] = drink_stock_reg[i];
        end
        for (int i = 0; i < COIN_TYPES; i++)
        begin
            coin_stock_next[i] = coin_stock_reg[i];
        end

        case (state_reg)
            ST_IDLE:
            begin
                // Take the transaction
                if (start)
                begin
                    func_next = func;
                    dsel_next = drink_sel;
                    csel_next = coin_sel;
                    if (func == vcc_pkg::FUNC_RETURN)
                    begin
                        state_next = ST_RET_LOAD;
                    end
                    else
                    begin
                        state_next = ST_EXEC;
                    end
                end
            end

            ST_EXEC:
            begin
                // Single-result events: credit or purchase
                strobe_next    = 1'b1;
                drink_idx_next = '0;
                coin_idx_next  = '0;
                count_next     = '0;
                left_next      = '0;
                last_next      = 1'b1;
                status_next    = vcc_pkg::STAT_CREDIT;
                if (func_reg == vcc_pkg::FUNC_SELECT)
                begin
                    drink_idx_next = dsel_reg;
                    if (vend_ok)
                    begin
                        status_next  = vcc_pkg::STAT_VEND;
                        balance_next = balance_reg - price_reg[dsel_reg];
                        for (int i = 0; i < DRINK_SLOTS; i++)
                        begin
                            if (vcc_pkg::SEL_W'(i) == dsel_reg)
                            begin
                                drink_stock_next[i] = drink_stock_reg[i] - 1'b1;
                            end
                        end
                    end
                    else
                    begin
                        status_next = vcc_pkg::STAT_REFUSE;
                    end
                    credit_next = vend_ok ? (balance_reg - price_reg[dsel_reg]) :
                                            balance_reg;
                end
                else
                begin
                    // Coin or dollar insert; saturate the balance
                    if (func_reg == vcc_pkg::FUNC_COIN && !coin_known)
                    begin
                        balance_next = balance_reg;
                    end
                    else
                    begin
                        balance_next = credit_sum[vcc_pkg::CENT_W] ?
                                       vcc_pkg::CENT_MAX :
                                       credit_sum[vcc_pkg::CENT_W-1:0];
                    end
                    if (func_reg == vcc_pkg::FUNC_COIN && coin_known &&
                        cstock_in_sel != vcc_pkg::STOCK_MAX)
                    begin
                        for (int i = 0; i < COIN_TYPES; i++)
                        begin
                            if (vcc_pkg::SEL_W'(i) == csel_reg)
                            begin
                                coin_stock_next[i] = coin_stock_reg[i] + 1'b1;
                            end
                        end
                    end
                    credit_next = balance_next;
                end
                state_next = ST_IDLE;
            end

            ST_RET_LOAD:
            begin
                // Move the balance into the change accumulator
                rest_next    = balance_reg;
                balance_next = '0;
                coin_k_next  = '0;
                state_next   = ST_DIV_GO;
            end

            ST_DIV_GO:
            begin
                // Divider starts this cycle; form the stock-limited payout
                prod_next  = {8'd0, cstock_k_sel} * {8'd0, value_k};
                state_next = ST_DIV_WAIT;
            end

            ST_DIV_WAIT:
            begin
                if (div_res.done)
                begin
                    state_next = ST_FIX;
                end
            end

            ST_FIX:
            begin
                strobe_next    = 1'b1;
                status_next    = vcc_pkg::STAT_CHANGE;
                credit_next    = '0;
                drink_idx_next = '0;
                coin_idx_next  = coin_k_reg;
                last_next      = last_coin;
                if (value_k == '0)
                begin
                    count_next = '0;
                    rest_next  = rest_reg;
                end
                else if (over_stock)
                begin
                    count_next = cstock_k_sel;
                    rest_next  = rest_reg - prod_reg;
                end
                else
                begin
                    count_next = div_res.quotient[vcc_pkg::STOCK_W-1:0];
                    rest_next  = {8'd0, div_res.remainder};
                end
                left_next = rest_next;
                for (int i = 0; i < COIN_TYPES; i++)
                begin
                    if (vcc_pkg::SEL_W'(i) == coin_k_reg)
                    begin
                        coin_stock_next[i] = coin_stock_reg[i] - count_next;
                    end
                end
                if (last_coin)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    coin_k_next = coin_k_reg + 1'b1;
                    state_next  = ST_DIV_GO;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            strobe_reg    <= 1'b0;
            balance_reg   <= '0;
            func_reg      <= vcc_pkg::FUNC_COIN;
            dsel_reg      <= '0;
            csel_reg      <= '0;
            coin_k_reg    <= '0;
            rest_reg      <= '0;
            prod_reg      <= '0;
            status_reg    <= vcc_pkg::STAT_CREDIT;
            credit_reg    <= '0;
            drink_idx_reg <= '0;
            coin_idx_reg  <= '0;
            count_reg     <= '0;
            left_reg      <= '0;
            last_reg      <= 1'b0;
            price_reg[0]  <= vcc_pkg::PRICE_INIT_0;
            price_reg[1]  <= vcc_pkg::PRICE_INIT_1;
            price_reg[2]  <= vcc_pkg::PRICE_INIT_2;
            price_reg[3]  <= vcc_pkg::PRICE_INIT_3;
            value_reg[0]  <= vcc_pkg::VALUE_INIT_0;
            value_reg[1]  <= vcc_pkg::VALUE_INIT_1;
            value_reg[2]  <= vcc_pkg::VALUE_INIT_2;
            for (int i = 0; i < DRINK_SLOTS; i++)
            begin
                drink_stock_reg[i] <= vcc_pkg::DRINK_STOCK_INIT;
            end
            for (int i = 0; i < COIN_TYPES; i++)
            begin
                coin_stock_reg[i] <= vcc_pkg::coin_stock_init(i);
            end
        end
        else
        begin
            state_reg     <= state_next;
            strobe_reg    <= strobe_next;
            balance_reg   <= balance_next;
            func_reg      <= func_next;
            dsel_reg      <= dsel_next;
            csel_reg      <= csel_next;
            coin_k_reg    <= coin_k_next;
            rest_reg      <= rest_next;
            prod_reg      <= prod_next;
            status_reg    <= status_next;
            credit_reg    <= credit_next;
            drink_idx_reg <= drink_idx_next;
            coin_idx_reg  <= coin_idx_next;
            count_reg     <= count_next;
            left_reg      <= left_next;
            last_reg      <= last_next;
            for (int i = 0; i < DRINK_SLOTS; i++)
            begin
                drink_stock_reg[i] <= drink_stock_next[i];
            end
            for (int i = 0; i < COIN_TYPES; i++)
            begin
                coin_stock_reg[i] <= coin_stock_next[i];
            end
            // Configuration writes; unlisted index is dropped
            if (cfg_we)
            begin
                case (cfg_index)
                    vcc_pkg::REG_PRICE_0: price_reg[0] <= cfg_data;
                    vcc_pkg::REG_PRICE_1: price_reg[1] <= cfg_data;
                    vcc_pkg::REG_PRICE_2: price_reg[2] <= cfg_data;
                    vcc_pkg::REG_PRICE_3: price_reg[3] <= cfg_data;
                    vcc_pkg::REG_VALUE_0: value_reg[0] <= cfg_data[vcc_pkg::VALUE_W-1:0];
                    vcc_pkg::REG_VALUE_1: value_reg[1] <= cfg_data[vcc_pkg::VALUE_W-1:0];
                    vcc_pkg::REG_VALUE_2: value_reg[2] <= cfg_data[vcc_pkg::VALUE_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    assign busy        = (state_reg != ST_IDLE);
    assign strobe      = strobe_reg;
    assign status      = status_reg;
    assign credit      = credit_reg;
    assign drink_index = drink_idx_reg;
    assign coin_index  = coin_idx_reg;
    assign coin_count  = count_reg;
    assign leftover    = left_reg;
    assign last        = last_reg;

endmodule

/* sv/vcc_divider.sv */
`timescale 1ns / 1ps

// Restoring divider: one quotient bit per cycle, MSB first.
module vcc_divider
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          go,
    input  logic [vcc_pkg::CENT_W-1:0]    dividend,
    input  logic [vcc_pkg::VALUE_W-1:0]   divisor,
    output vcc_pkg::div_result_t          res
);

    logic                              run_reg;
    logic                              done_reg;
    logic [vcc_pkg::DIV_CNT_W-1:0]     cnt_reg;
    logic [vcc_pkg::CENT_W-1:0]        quo_reg;
    logic [vcc_pkg::VALUE_W-1:0]       rem_reg;
    logic [vcc_pkg::VALUE_W-1:0]       dvs_reg;

    logic [vcc_pkg::VALUE_W:0]         trial;
    logic                              qbit;
    logic [vcc_pkg::VALUE_W-1:0]       rem_next;

    assign trial = {rem_reg, quo_reg[vcc_pkg::CENT_W-1]};
    assign qbit  = (trial >= {1'b0, dvs_reg});

    always_comb
    begin
        if (qbit)
        begin
            rem_next = vcc_pkg::VALUE_W'(trial - {1'b0, dvs_reg});
        end
        else
        begin
            rem_next = trial[vcc_pkg::VALUE_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (go)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == vcc_pkg::DIV_CNT_W'(vcc_pkg::DIV_STEPS - 1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: load on go, shift one bit per step
    always_ff @(posedge clk)
    begin
        if (go)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (run_reg)
        begin
            quo_reg <= {quo_reg[vcc_pkg::CENT_W-2:0], qbit};
            rem_reg <= rem_next;
        end
    end

    assign res.done      = done_reg;
    assign res.quotient  = quo_reg;
    assign res.remainder = rem_reg;

endmodule

/* test/vending_change_controller_unit_test.sv */
`timescale 1ns / 1ps

// Self-checking bench for the vending change controller. A short scripted
// run from reset comes first, then several phases of random transactions,
// each under its own set of prices and coin values and its own rate of
// sender idling. Every accepted transaction goes through a local model of
// credit, drink stock and coin stock. The model queues the results due,
// and every strobed result is checked against the oldest one.
module vending_change_controller_unit_test;
    import vcc_pkg::*;

    localparam int DRINKS        = NUM_DRINKS_DEF;
    localparam int COINS         = NUM_COINS_DEF;
    localparam int QUIET_LIMIT   = 2000;   // cycles without any transaction or result
    localparam int SETTLE_CYCLES = 80;     // covers a full three-coin return
    localparam int SCRIPT_LEN    = 16;

    // Write data to this index must be ignored by the block
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [CENT_W-1:0]   credit;
        logic [SEL_W-1:0]    drink_index;
        logic [SEL_W-1:0]    coin_index;
        logic [STOCK_W-1:0]  coin_count;
        logic [CENT_W-1:0]   leftover;
        logic                last;
    } vend_result_t;

    // One scripted transaction; when pinned, status and credit are typed in
    typedef struct packed {
        logic [FUNC_W-1:0]   op;
        logic [SEL_W-1:0]    drink;
        logic [SEL_W-1:0]    coin;
        logic                pinned;
        logic [STATUS_W-1:0] status;
        logic [CENT_W-1:0]   credit;
    } script_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    logic [FUNC_W-1:0]     func;
    logic [SEL_W-1:0]      drink_sel;
    logic [SEL_W-1:0]      coin_sel;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  strobe;
    logic [STATUS_W-1:0]   status;
    logic [CENT_W-1:0]     credit;
    logic [SEL_W-1:0]      drink_index;
    logic [SEL_W-1:0]      coin_index;
    logic [STOCK_W-1:0]    coin_count;
    logic [CENT_W-1:0]     leftover;
    logic                  last;

    // Local model of the machine: registers and stock
    logic [CENT_W-1:0]  price_now [PRICE_REGS];
    logic [VALUE_W-1:0] value_now [VALUE_REGS];
    logic [CENT_W-1:0]  balance_now;
    logic [STOCK_W-1:0] drink_left [DRINKS];
    logic [STOCK_W-1:0] coins_left [COINS];

    vend_result_t awaited_results[$];

    int mismatches;
    int quiet_cycles;
    int idle_pct;

    // Typed-in status and credit for the transaction being driven
    logic                pin_on;
    logic [STATUS_W-1:0] pin_status;
    logic [CENT_W-1:0]   pin_credit;

    // Scripted opening run, starting from the reset prices 75/75/80/80 and
    // coin values 25/10/5. Returns are left to the model.
    script_row_t script [SCRIPT_LEN] = '{
        '{FUNC_SELECT, 2'd0, 2'd2, 1'b1, STAT_REFUSE, 16'd0},   // no credit yet
        '{FUNC_COIN,   2'd3, 2'd0, 1'b1, STAT_CREDIT, 16'd25},
        '{FUNC_COIN,   2'd2, 2'd1, 1'b1, STAT_CREDIT, 16'd35},
        '{FUNC_COIN,   2'd1, 2'd2, 1'b1, STAT_CREDIT, 16'd40},
        '{FUNC_COIN,   2'd0, 2'd3, 1'b1, STAT_CREDIT, 16'd40},  // unknown coin
        '{FUNC_DOLLAR, 2'd3, 2'd3, 1'b1, STAT_CREDIT, 16'd140},
        '{FUNC_SELECT, 2'd3, 2'd1, 1'b1, STAT_VEND,   16'd60},
        '{FUNC_SELECT, 2'd1, 2'd0, 1'b1, STAT_REFUSE, 16'd60},  // short of price
        '{FUNC_RETURN, 2'd2, 2'd1, 1'b0, STAT_CREDIT, 16'd0},
        '{FUNC_RETURN, 2'd1, 2'd3, 1'b0, STAT_CREDIT, 16'd0},   // nothing to pay
        '{FUNC_DOLLAR, 2'd0, 2'd2, 1'b1, STAT_CREDIT, 16'd100},
        '{FUNC_SELECT, 2'd2, 2'd3, 1'b1, STAT_VEND,   16'd20},
        '{FUNC_COIN,   2'd3, 2'd3, 1'b1, STAT_CREDIT, 16'd20},
        '{FUNC_COIN,   2'd0, 2'd2, 1'b1, STAT_CREDIT, 16'd25},
        '{FUNC_RETURN, 2'd3, 2'd0, 1'b0, STAT_CREDIT, 16'd0},
        '{FUNC_SELECT, 2'd0, 2'd0, 1'b1, STAT_REFUSE, 16'd0}
    };

    vending_change_controller_unit i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .func        (func),
        .drink_sel   (drink_sel),
        .coin_sel    (coin_sel),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .strobe      (strobe),
        .status      (status),
        .credit      (credit),
        .drink_index (drink_index),
        .coin_index  (coin_index),
        .coin_count  (coin_count),
        .leftover    (leftover),
        .last        (last)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Clamp the balance at its top value
    function automatic logic [CENT_W-1:0] credit_plus(input logic [CENT_W-1:0] bal,
                                                     input int unsigned amount);
        int unsigned sum;
        sum = 32'(bal) + amount;
        return (sum > 32'(CENT_MAX)) ? CENT_MAX : sum[CENT_W-1:0];
    endfunction

    // Advance the local model by one accepted transaction and queue the
    // results it must produce.
    task automatic predict_vend(input logic [FUNC_W-1:0] op,
                                input logic [SEL_W-1:0] dsel,
                                input logic [SEL_W-1:0] csel);
        vend_result_t r;
        int unsigned  rest;
        int unsigned  v;
        int unsigned  n;
        r = '0;
        r.last = 1'b1;
        case (op)
            FUNC_COIN:
            begin
                // Unknown coin types leave everything alone
                if (csel < COINS)
                begin
                    if (coins_left[csel] != STOCK_MAX)
                        coins_left[csel] = coins_left[csel] + 1'b1;
                    balance_now = credit_plus(balance_now, 32'(value_now[csel]));
                end
                r.status = STAT_CREDIT;
                r.credit = balance_now;
            end
            FUNC_DOLLAR:
            begin
                balance_now = credit_plus(balance_now, 32'(DOLLAR_CENTS));
                r.status = STAT_CREDIT;
                r.credit = balance_now;
            end
            FUNC_SELECT:
            begin
                r.status = STAT_REFUSE;
                if (dsel < DRINKS && drink_left[dsel] != 0 && balance_now >= price_now[dsel])
                begin
                    drink_left[dsel] = drink_left[dsel] - 1'b1;
                    balance_now = balance_now - price_now[dsel];
                    r.status = STAT_VEND;
                end
                r.credit = balance_now;
                r.drink_index = dsel;
            end
            default:
            begin
                // Greedy payout in coin index order, each limited by stock
                rest = 32'(balance_now);
                balance_now = '0;
                for (int k = 0; k < COINS; k++)
                begin
                    v = 32'(value_now[k]);
                    n = 0;
                    if (v != 0)
                    begin
                        n = rest / v;
                        if (n > 32'(coins_left[k]))
                            n = 32'(coins_left[k]);
                    end
                    rest = rest - n * v;
                    coins_left[k] = coins_left[k] - n[STOCK_W-1:0];
                    r = '0;
                    r.status = STAT_CHANGE;
                    r.coin_index = k[SEL_W-1:0];
                    r.coin_count = n[STOCK_W-1:0];
                    r.leftover = rest[CENT_W-1:0];
                    r.last = (k == COINS - 1);
                    awaited_results.push_back(r);
                end
            end
        endcase
        if (op != FUNC_RETURN)
        begin
            if (pin_on)
            begin
                r.status = pin_status;
                r.credit = pin_credit;
            end
            awaited_results.push_back(r);
        end
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want)
        begin
            mismatches++;
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    // Sample at the rising edge: check results, track register writes and
    // predict every transaction the block takes.
    always @(posedge clk)
    begin : monitor
        vend_result_t want;
        if (rst_n)
        begin
            if (strobe)
            begin
                if (awaited_results.size() == 0)
                begin
                    mismatches++;
                    $display("%0t ns: result with none awaited, expected nothing, actual %p",
                             $time, {status, credit, drink_index, coin_index, coin_count,
                                     leftover, last});
                end
                else
                begin
                    want = awaited_results.pop_front();
                    compare_field("status", 32'(want.status), 32'(status));
                    compare_field("credit", 32'(want.credit), 32'(credit));
                    compare_field("drink_index", 32'(want.drink_index), 32'(drink_index));
                    compare_field("coin_index", 32'(want.coin_index), 32'(coin_index));
                    compare_field("coin_count", 32'(want.coin_count), 32'(coin_count));
                    compare_field("leftover", 32'(want.leftover), 32'(leftover));
                    compare_field("last", 32'(want.last), 32'(last));
                end
            end
            if (cfg_we)
            begin
                if (cfg_index < PRICE_REGS)
                    price_now[cfg_index] = cfg_data;
                else if (cfg_index < PRICE_REGS + VALUE_REGS)
                    value_now[cfg_index - PRICE_REGS] = cfg_data[VALUE_W-1:0];
            end
            if (start && !busy)
                predict_vend(func, drink_sel, coin_sel);
        end
    end

    // End the run when neither side moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || strobe || (start && !busy))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("%0t ns: timeout, no transaction or result for %0d cycles",
                     $time, QUIET_LIMIT);
            $display("== FAIL ==");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Drive one transaction: idle at random first, then hold start until
    // the block takes it. Entered and left just after a falling edge.
    task automatic put_txn(input logic [FUNC_W-1:0] op, input logic [SEL_W-1:0] dsel,
                           input logic [SEL_W-1:0] csel);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start     <= 1'b1;
        func      <= op;
        drink_sel <= dsel;
        coin_sel  <= csel;
        @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Mostly credit, some purchases, an occasional return; unknown coins rare
    task automatic put_random_txn();
        int                pick;
        logic [FUNC_W-1:0] op;
        logic [SEL_W-1:0]  csel;
        pick = $urandom_range(99);
        if (pick < 48)
            op = FUNC_COIN;
        else if (pick < 68)
            op = FUNC_DOLLAR;
        else if (pick < 88)
            op = FUNC_SELECT;
        else
            op = FUNC_RETURN;
        csel = ($urandom_range(9) == 0) ? 2'd3 : SEL_W'($urandom_range(2));
        put_txn(op, SEL_W'($urandom_range(3)), csel);
    endtask

    // Drop start and hold until every awaited result is in and busy is low
    task automatic settle();
        start <= 1'b0;
        while (awaited_results.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
    endtask

    // Write all prices and coin values; junk goes into the unused upper
    // byte of the value registers and into the unused index.
    task automatic program_regs(input logic [CENT_W-1:0] p0, input logic [CENT_W-1:0] p1,
                                input logic [CENT_W-1:0] p2, input logic [CENT_W-1:0] p3,
                                input logic [VALUE_W-1:0] v0, input logic [VALUE_W-1:0] v1,
                                input logic [VALUE_W-1:0] v2);
        logic [7:0] junk;
        write_reg(REG_PRICE_0, p0);
        write_reg(REG_PRICE_1, p1);
        write_reg(REG_PRICE_2, p2);
        write_reg(REG_PRICE_3, p3);
        junk = 8'($urandom);
        write_reg(REG_VALUE_0, {junk, v0});
        junk = 8'($urandom);
        write_reg(REG_VALUE_1, {junk, v1});
        junk = 8'($urandom);
        write_reg(REG_VALUE_2, {junk, v2});
        write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
        cfg_we <= 1'b0;
    endtask

    task automatic program_random_regs();
        program_regs(CENT_W'($urandom_range(400)), CENT_W'($urandom_range(400)),
                     CENT_W'($urandom_range(400)), CENT_W'($urandom_range(400)),
                     VALUE_W'($urandom_range(255)), VALUE_W'($urandom_range(255)),
                     VALUE_W'($urandom_range(255)));
    endtask

    initial
    begin
        // Hold every input at a known value from time zero
        rst_n        = 1'b0;
        start        = 1'b0;
        func         = FUNC_COIN;
        drink_sel    = '0;
        coin_sel     = '0;
        cfg_we       = 1'b0;
        cfg_index    = REG_PRICE_0;
        cfg_data     = '0;
        mismatches   = 0;
        quiet_cycles = 0;
        idle_pct     = 0;
        pin_on       = 1'b0;
        pin_status   = STAT_CREDIT;
        pin_credit   = '0;

        // Model state after reset
        price_now[0] = PRICE_INIT_0;
        price_now[1] = PRICE_INIT_1;
        price_now[2] = PRICE_INIT_2;
        price_now[3] = PRICE_INIT_3;
        value_now[0] = VALUE_INIT_0;
        value_now[1] = VALUE_INIT_1;
        value_now[2] = VALUE_INIT_2;
        balance_now  = '0;
        for (int d = 0; d < DRINKS; d++)
            drink_left[d] = DRINK_STOCK_INIT;
        coins_left[0] = 8'd5;
        coins_left[1] = 8'd5;
        coins_left[2] = 8'd10;

        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Scripted run at reset settings, back to back
        for (int i = 0; i < SCRIPT_LEN; i++)
        begin
            pin_on     = script[i].pinned;
            pin_status = script[i].status;
            pin_credit = script[i].credit;
            put_txn(script[i].op, script[i].drink, script[i].coin);
        end
        pin_on = 1'b0;

        // Free drink 0, unaffordable drink 1, one-cent drink 2, and a coin
        // type worth nothing on the smallest slot
        settle();
        program_regs(16'd0, CENT_MAX, 16'd1, 16'd150, 8'd255, 8'd1, 8'd0);
        idle_pct = 0;
        repeat (70) put_random_txn();

        settle();
        program_random_regs();
        idle_pct = 56;
        repeat (70) put_random_txn();

        // Saturation: pile up top-value coins until balance and coin stock
        // clip, then return at the limit and buy at exactly the price
        settle();
        program_regs(CENT_MAX, 16'd255, 16'd3, 16'hFFFE, 8'd255, 8'd255, 8'd255);
        idle_pct = 9;
        repeat (300)
        begin
            if ($urandom_range(99) < 90)
                put_txn(FUNC_COIN, SEL_W'($urandom_range(3)), 2'd0);
            else if ($urandom_range(1) == 0)
                put_txn(FUNC_DOLLAR, SEL_W'($urandom_range(3)), SEL_W'($urandom_range(3)));
            else
                put_txn(FUNC_COIN, SEL_W'($urandom_range(3)), SEL_W'($urandom_range(3)));
        end
        put_txn(FUNC_DOLLAR, 2'd2, 2'd1);
        put_txn(FUNC_RETURN, 2'd1, 2'd2);
        put_txn(FUNC_COIN, 2'd0, 2'd0);
        put_txn(FUNC_SELECT, 2'd1, 2'd3);
        put_txn(FUNC_SELECT, 2'd0, 2'd0);

        // Back to the reset settings
        settle();
        program_regs(PRICE_INIT_0, PRICE_INIT_1, PRICE_INIT_2, PRICE_INIT_3,
                     VALUE_INIT_0, VALUE_INIT_1, VALUE_INIT_2);
        idle_pct = 56;
        repeat (60) put_random_txn();

        settle();
        program_random_regs();
        idle_pct = 9;
        repeat (50) put_random_txn();

        // Drain, then watch a while for stray results
        settle();
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
